@@ rtl/msctb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msctb_pkg: shared types and codes of the countdown timer bank
// Channel payloads, slot record, opcodes and timer kinds.
// ----------------------------------------------------------------------------
package msctb_pkg;

	localparam int SLOT_ID_W = 5;
	localparam int COUNT_W   = 32;
	localparam int STEP_W    = 16;

	typedef logic [2:0]         opcode_t;
	typedef logic [2:0]         kind_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam opcode_t OP_TICK    = 3'd0;
	localparam opcode_t OP_RUN     = 3'd1;
	localparam opcode_t OP_REFRESH = 3'd2;
	localparam opcode_t OP_DELAY   = 3'd3;
	localparam opcode_t OP_STOP    = 3'd4;
	localparam opcode_t OP_QUERY   = 3'd5;

	localparam kind_t KIND_NONE         = 3'd0;
	localparam kind_t KIND_ONESHOT_DEF  = 3'd1;
	localparam kind_t KIND_PERIODIC_DEF = 3'd2;
	localparam kind_t KIND_ONESHOT_IMM  = 3'd3;
	localparam kind_t KIND_PERIODIC_IMM = 3'd4;

	localparam step_t STEP_RESET = 16'd1;

	typedef struct packed {
		opcode_t                opcode;
		logic [SLOT_ID_W-1:0]   slot_id;
		kind_t                  timer_kind;
		count_t                 start_delay;
		count_t                 period_value;
		logic                   has_action;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_ID_W-1:0]   result_slot;
		logic                   ok;
		logic                   is_fire;
		logic                   deferred;
		logic                   last;
	} rsp_t;

	typedef struct packed {
		kind_t  kind;
		logic   action;
		count_t delay;
		count_t period;
		count_t remaining;
	} slot_t;

	typedef struct packed {
		logic emit;
		logic free_slot;
		logic deferred;
	} tick_res_t;

endpackage

@@ rtl/msctb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msctb_if: channel interfaces of the countdown timer bank
// Command, response and step-configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface msctb_cmd_if;
	logic              valid;
	logic              ready;
	msctb_pkg::cmd_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface msctb_rsp_if;
	logic              valid;
	logic              ready;
	msctb_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface msctb_cfg_if;
	logic              valid;
	logic              ready;
	msctb_pkg::step_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/msctb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msctb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msctb_ram #(
	parameter int WIDTH = 100,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/msctb_tick_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msctb_tick_unit: shared decrement and compare unit
// Advances one slot by one tick: delay first, then remaining count, clamped
// at zero; reloads periodic timers and reports fire, release and deferral.
// ----------------------------------------------------------------------------
module msctb_tick_unit (
	input  msctb_pkg::slot_t     cur,
	input  msctb_pkg::step_t     step,
	output msctb_pkg::slot_t     nxt,
	output msctb_pkg::tick_res_t res
);

	msctb_pkg::count_t operand;
	msctb_pkg::count_t step_w;
	msctb_pkg::count_t diff;
	logic              in_delay;
	logic              zero;
	logic              periodic;
	logic              oneshot;

	always_comb begin
		step_w   = msctb_pkg::COUNT_W'(step);
		in_delay = (cur.delay != '0);
		operand  = in_delay ? cur.delay : cur.remaining;
		diff     = (operand > step_w) ? (operand - step_w) : '0;

		nxt = cur;
		if (in_delay) begin
			nxt.delay = diff;
		end else begin
			nxt.remaining = diff;
		end

		periodic = (cur.kind == msctb_pkg::KIND_PERIODIC_DEF) ||
			(cur.kind == msctb_pkg::KIND_PERIODIC_IMM);
		oneshot  = (cur.kind == msctb_pkg::KIND_ONESHOT_DEF) ||
			(cur.kind == msctb_pkg::KIND_ONESHOT_IMM);
		zero     = (nxt.remaining == '0);

		// reload
		if (zero && periodic) begin
			nxt.remaining = cur.period;
		end

		res.emit      = zero && cur.action;
		res.free_slot = zero && oneshot;
		res.deferred  = (cur.kind == msctb_pkg::KIND_ONESHOT_DEF) ||
			(cur.kind == msctb_pkg::KIND_PERIODIC_DEF);
	end

endmodule

@@ rtl/multi_slot_countdown_timer_bank_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_bank_top: bank of countdown timer slots
// Command-driven timer bank with one shared tick unit and a slot RAM.
// ----------------------------------------------------------------------------
// Each command word is taken only while the sequencer is idle. A tick walks
// all SLOT_COUNT slots through one shared decrement and compare unit, one
// slot per cycle out of the slot RAM unless response backpressure holds up a
// fire word, and then releases the final fire word. A run scans the busy bits
// one slot per cycle for the first free slot; refresh and set-delay on an
// active slot read and write the slot RAM. A reply also waits while the
// response register is full. Fire words leave in slot order, the final one
// of a tick marked last; a tick with no fire returns no word. The step
// register is written only while the sequencer is idle.
module multi_slot_countdown_timer_bank_top #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	msctb_cmd_if.sink   cmd,
	msctb_rsp_if.source rsp,
	msctb_cfg_if.sink   cfg
);

	localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDW = msctb_pkg::SLOT_ID_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TICK  = 3'd1;
	localparam logic [2:0] S_FLUSH = 3'd2;
	localparam logic [2:0] S_FIND  = 3'd3;
	localparam logic [2:0] S_RMW   = 3'd4;
	localparam logic [2:0] S_REPLY = 3'd5;

	logic [2:0]              state_q;
	logic [IW-1:0]           idx_q;
	logic [SLOT_COUNT-1:0]   active_q;
	msctb_pkg::step_t        step_q;
	msctb_pkg::cmd_t         cmd_q;
	msctb_pkg::rsp_t         reply_q;
	logic                    held_valid_q;
	msctb_pkg::rsp_t         held_q;
	logic                    out_valid_q;
	msctb_pkg::rsp_t         out_q;

	logic [IDW-1:0]          id_m1;
	logic [IW-1:0]           sel_idx;
	logic                    id_ok;
	logic                    found;
	logic                    accept;
	logic                    out_free;
	logic [IW-1:0]           idx_inc;
	logic                    last_idx;
	logic                    tick_act;
	logic                    tick_stall;
	logic                    tick_adv;
	logic [IDW-1:0]          idx_id;
	msctb_pkg::rsp_t         fire_word;
	logic                    out_load;
	msctb_pkg::rsp_t         out_word;

	msctb_pkg::slot_t        cur_slot;
	msctb_pkg::slot_t        nxt_slot;
	msctb_pkg::tick_res_t    tres;

	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	msctb_pkg::slot_t        ram_wdata;
	logic [IW-1:0]           ram_raddr;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign id_m1   = cmd.data.slot_id - IDW'(1);
	assign sel_idx = IW'(id_m1);
	assign id_ok   = (cmd.data.slot_id != '0) &&
		(32'(cmd.data.slot_id) <= 32'(SLOT_COUNT));
	assign found   = id_ok && active_q[sel_idx];

	assign idx_inc    = idx_q + IW'(1);
	assign last_idx   = (idx_q == LAST_IDX);
	assign idx_id     = IDW'(idx_q) + IDW'(1);
	assign tick_act   = active_q[idx_q];
	assign tick_stall = tick_act && tres.emit && held_valid_q && !out_free;
	assign tick_adv   = (state_q == S_TICK) && !tick_stall;

	always_comb begin
		fire_word.result_slot = idx_id;
		fire_word.ok          = 1'b1;
		fire_word.is_fire     = 1'b1;
		fire_word.deferred    = tres.deferred;
		fire_word.last        = 1'b0;
	end

	always_comb begin
		out_load = 1'b0;
		out_word = reply_q;
		unique case (state_q)
			S_TICK: begin
				if (tick_adv && tick_act && tres.emit && held_valid_q) begin
					out_load = 1'b1;
					out_word = held_q;
				end
			end
			S_FLUSH: begin
				if (held_valid_q && out_free) begin
					out_load      = 1'b1;
					out_word      = held_q;
					out_word.last = 1'b1;
				end
			end
			S_REPLY: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	msctb_tick_unit u_tick (
		.cur  (cur_slot),
		.step (step_q),
		.nxt  (nxt_slot),
		.res  (tres)
	);

	msctb_ram #(
		.WIDTH ($bits(msctb_pkg::slot_t)),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (cur_slot)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cur_slot;
		ram_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = (cmd.data.opcode == msctb_pkg::OP_TICK) ? '0 : sel_idx;
			end
			S_TICK: begin
				if (tick_adv) begin
					ram_we    = tick_act;
					ram_wdata = nxt_slot;
					ram_raddr = last_idx ? '0 : idx_inc;
				end
			end
			S_FIND: begin
				ram_we              = !active_q[idx_q];
				ram_wdata.kind      = cmd_q.timer_kind;
				ram_wdata.action    = cmd_q.has_action;
				ram_wdata.delay     = cmd_q.start_delay;
				ram_wdata.period    = cmd_q.period_value;
				ram_wdata.remaining = cmd_q.period_value;
			end
			S_RMW: begin
				ram_we = 1'b1;
				if (cmd_q.opcode == msctb_pkg::OP_REFRESH) begin
					ram_wdata.period    = cmd_q.period_value;
					ram_wdata.remaining = cmd_q.period_value;
				end else begin
					ram_wdata.delay = cmd_q.start_delay;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			active_q     <= '0;
			step_q       <= msctb_pkg::STEP_RESET;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				step_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_word;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q               <= cmd.data;
						reply_q.result_slot <= '0;
						reply_q.is_fire     <= 1'b0;
						reply_q.deferred    <= 1'b0;
						reply_q.last        <= 1'b1;
						unique case (cmd.data.opcode)
							msctb_pkg::OP_TICK: begin
								reply_q.ok <= 1'b0;
								idx_q      <= '0;
								state_q    <= S_TICK;
							end
							msctb_pkg::OP_RUN: begin
								reply_q.ok <= 1'b0;
								idx_q      <= '0;
								if (cmd.data.timer_kind <= msctb_pkg::KIND_PERIODIC_IMM) begin
									state_q <= S_FIND;
								end else begin
									state_q <= S_REPLY;
								end
							end
							msctb_pkg::OP_REFRESH, msctb_pkg::OP_DELAY: begin
								reply_q.ok <= found;
								if (found) begin
									idx_q   <= sel_idx;
									state_q <= S_RMW;
								end else begin
									idx_q   <= '0;
									state_q <= S_REPLY;
								end
							end
							msctb_pkg::OP_STOP: begin
								reply_q.ok <= found;
								idx_q      <= '0;
								state_q    <= S_REPLY;
								if (found) begin
									active_q[sel_idx] <= 1'b0;
								end
							end
							msctb_pkg::OP_QUERY: begin
								reply_q.ok <= found;
								idx_q      <= '0;
								state_q    <= S_REPLY;
							end
							default: begin
								reply_q.ok <= 1'b0;
								idx_q      <= '0;
								state_q    <= S_REPLY;
							end
						endcase
					end
				end
				S_TICK: begin
					if (tick_adv) begin
						if (tick_act && tres.free_slot) begin
							active_q[idx_q] <= 1'b0;
						end
						// hold the newest fire until the next one shows whether it is last
						if (tick_act && tres.emit) begin
							held_valid_q <= 1'b1;
							held_q       <= fire_word;
						end
						if (last_idx) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				S_FLUSH: begin
					if (!held_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_FIND: begin
					if (!active_q[idx_q]) begin
						if (cmd_q.timer_kind != msctb_pkg::KIND_NONE) begin
							active_q[idx_q] <= 1'b1;
						end
						reply_q.result_slot <= idx_id;
						reply_q.ok          <= 1'b1;
						state_q             <= S_REPLY;
					end else if (last_idx) begin
						state_q <= S_REPLY;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_RMW: begin
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_held_only_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (state_q == S_TICK || state_q == S_FLUSH))
		else $error("fire word held outside a tick");

	a_reply_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.is_fire) |-> out_q.last)
		else $error("operation reply not marked last");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (32'(idx_q) < 32'(SLOT_COUNT)))
		else $error("slot index beyond bank");

	a_flush_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (idx_q == LAST_IDX))
		else $error("tick flush before the scan finished");

endmodule
